FILE: sv/sspf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the servo status frame parser.
// Depends on nothing; every other file but sspf_ram refers to it by scoped names.

package sspf_pkg;

  localparam int MAX_LENGTH_FIELD = 20;
  localparam int MIN_LENGTH_FIELD = 2;
  localparam int STORE_DEPTH      = MAX_LENGTH_FIELD - MIN_LENGTH_FIELD;
  localparam int STORE_AW         = $clog2(STORE_DEPTH);
  localparam int CNT_W            = 5;
  localparam int BYTE_W           = 8;

  localparam logic [BYTE_W-1:0] HDR_BYTE = 8'hFF;

  // Configuration register indexes.
  localparam logic [0:0] CFG_EXPECTED_ID  = 1'b0;
  localparam logic [0:0] CFG_WANTED_COUNT = 1'b1;

  // Input item codes.
  localparam logic FUNC_BYTE  = 1'b0;
  localparam logic FUNC_START = 1'b1;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_ID,
    PH_LEN,
    PH_ERR,
    PH_DATA,
    PH_CHK,
    PH_DONE
  } phase_t;

  // Frame accepted: hand the delivery count to the drain unit.
  typedef struct packed {
    logic             fire;
    logic [CNT_W-1:0] count;
  } accept_t;

  // Drain progress, used by the parser to avoid overwriting unread entries.
  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] rd_idx;
  } drain_stat_t;

endpackage

FILE: sv/servo_status_frame_parser.sv
`timescale 1ns / 1ps
// Top level of the servo status frame parser: configuration registers,
// parser, payload store and drain unit. Depends on sspf_pkg and all sspf_* modules.
//
// Usage: each input transaction carries one received UART byte (in_func low)
// or a start command (in_func high) that clears the parser for a new request.
// The parser hunts for two 0xFF header bytes, then takes id, length, error,
// payload and checksum. A frame with the expected id, a zero error byte, a
// good checksum and at least wanted_count payload bytes is delivered as
// wanted_count output transactions (data byte, index, last flag); all other
// frames are dropped without output. After a delivered frame, bytes are ignored
// until the next start.
// Throughput: one input transaction per cycle. The payload store is one
// 18-entry RAM with one write and one read port; the first output follows the
// checksum byte through the read index, RAM read and output registers, then one
// byte per cycle while the receiver does not stall. A stalled receiver holds
// the output register and a one-entry skid stage; input keeps flowing except
// when a new frame's payload write would overwrite an entry not yet read, which
// stalls the input side. Reset restores expected_id = 1 and wanted_count = 2,
// clears the parser and empties the output path. The store itself needs no
// clearing: results only read entries written by the frame being delivered.

module servo_status_frame_parser (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_func,
  input  logic [sspf_pkg::BYTE_W-1:0]         in_rx_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [sspf_pkg::BYTE_W-1:0]         out_data_byte,
  output logic [sspf_pkg::CNT_W-1:0]          out_byte_index,
  output logic                                out_last,
  input  logic                                cfg_we,
  input  logic [0:0]                          cfg_index,
  input  logic [sspf_pkg::BYTE_W-1:0]         cfg_wdata
);

  logic [sspf_pkg::BYTE_W-1:0]   expected_id_r;
  logic [sspf_pkg::CNT_W-1:0]    wanted_count_r;

  sspf_pkg::accept_t             accept;
  sspf_pkg::drain_stat_t         drain_stat;
  logic                          wr_en;
  logic [sspf_pkg::STORE_AW-1:0] wr_addr;
  logic [sspf_pkg::BYTE_W-1:0]   wr_data;
  logic                          rd_en;
  logic [sspf_pkg::STORE_AW-1:0] rd_addr;
  logic [sspf_pkg::BYTE_W-1:0]   rd_data;

  // Configuration registers; the user must write them only while idle (unenforced).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_id_r  <= 8'd1;
      wanted_count_r <= 5'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sspf_pkg::CFG_EXPECTED_ID:  expected_id_r  <= cfg_wdata;
        sspf_pkg::CFG_WANTED_COUNT: wanted_count_r <= cfg_wdata[sspf_pkg::CNT_W-1:0];
        default:                    expected_id_r  <= expected_id_r;
      endcase
    end
  end

  sspf_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_rx_byte   (in_rx_byte),
    .expected_id  (expected_id_r),
    .wanted_count (wanted_count_r),
    .drain_stat   (drain_stat),
    .accept       (accept),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data)
  );

  sspf_ram #(
    .WIDTH (sspf_pkg::BYTE_W),
    .DEPTH (sspf_pkg::STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sspf_drain u_drain (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .drain_stat     (drain_stat),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data_byte  (out_data_byte),
    .out_byte_index (out_byte_index),
    .out_last       (out_last)
  );

`ifndef NO_ASSERTIONS
  a_out_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_byte_index < sspf_pkg::CNT_W'(sspf_pkg::STORE_DEPTH)))
    else $error("delivered index beyond the payload store");

  a_last_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |->
      (out_byte_index == wanted_count_r - sspf_pkg::CNT_W'(1)))
    else $error("last flag on the wrong delivered byte");

  a_stall_only_when_draining: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> drain_stat.busy)
    else $error("input stalled with no reads outstanding");
`endif

endmodule

FILE: sv/sspf_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with a registered read.
// Standalone; no package dependency.

module sspf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 18
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

FILE: sv/sspf_parser.sv
`timescale 1ns / 1ps
// Header hunt and frame field parser; writes payload bytes to the store.
// Depends on sspf_pkg.

module sspf_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_func,
  input  logic [sspf_pkg::BYTE_W-1:0]   in_rx_byte,
  input  logic [sspf_pkg::BYTE_W-1:0]   expected_id,
  input  logic [sspf_pkg::CNT_W-1:0]    wanted_count,
  input  sspf_pkg::drain_stat_t         drain_stat,
  output sspf_pkg::accept_t             accept,
  output logic                          wr_en,
  output logic [sspf_pkg::STORE_AW-1:0] wr_addr,
  output logic [sspf_pkg::BYTE_W-1:0]   wr_data
);

  sspf_pkg::phase_t phase_r, phase_nxt;
  logic                         prev_sync_r, prev_sync_nxt;
  logic [sspf_pkg::BYTE_W-1:0]  ident_r, ident_nxt;
  logic [sspf_pkg::CNT_W-1:0]   length_r, length_nxt;
  logic [sspf_pkg::BYTE_W-1:0]  status_r, status_nxt;
  logic [sspf_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [sspf_pkg::BYTE_W-1:0]  sum_r, sum_nxt;

  logic                         in_fire;
  logic                         is_start;
  logic                         len_bad;
  logic                         chk_pass;
  logic [sspf_pkg::CNT_W-1:0]   len_m2;
  logic [sspf_pkg::CNT_W-1:0]   count_inc;
  logic [sspf_pkg::BYTE_W-1:0]  sum_add;

  // Hold off a payload write whose entry the drain has not read yet.
  assign in_stall = drain_stat.busy && (phase_r == sspf_pkg::PH_DATA) &&
                    (count_r >= drain_stat.rd_idx);
  assign in_fire  = in_valid && !in_stall;
  assign is_start = (in_func == sspf_pkg::FUNC_START);

  assign len_bad   = (in_rx_byte < sspf_pkg::BYTE_W'(sspf_pkg::MIN_LENGTH_FIELD)) ||
                     (in_rx_byte > sspf_pkg::BYTE_W'(sspf_pkg::MAX_LENGTH_FIELD));
  assign len_m2    = length_r - sspf_pkg::CNT_W'(sspf_pkg::MIN_LENGTH_FIELD);
  assign count_inc = count_r + sspf_pkg::CNT_W'(1);
  assign sum_add   = sum_r + in_rx_byte;
  assign chk_pass  = (ident_r == expected_id) && (status_r == '0) &&
                     (in_rx_byte == ~sum_r) && (len_m2 >= wanted_count) &&
                     (wanted_count <= sspf_pkg::CNT_W'(sspf_pkg::STORE_DEPTH));

  always_comb begin
    phase_nxt = phase_r;
    if (in_fire) begin
      if (is_start) begin
        phase_nxt = sspf_pkg::PH_HUNT;
      end else begin
        unique case (phase_r)
          sspf_pkg::PH_ID:   phase_nxt = sspf_pkg::PH_LEN;
          sspf_pkg::PH_LEN: begin
            if (!len_bad) begin
              phase_nxt = sspf_pkg::PH_ERR;
            end else if (ident_r == sspf_pkg::HDR_BYTE) begin
              phase_nxt = sspf_pkg::PH_LEN;
            end else begin
              phase_nxt = sspf_pkg::PH_HUNT;
            end
          end
          sspf_pkg::PH_ERR: begin
            phase_nxt = (length_r > sspf_pkg::CNT_W'(sspf_pkg::MIN_LENGTH_FIELD)) ?
                        sspf_pkg::PH_DATA : sspf_pkg::PH_CHK;
          end
          sspf_pkg::PH_DATA: begin
            phase_nxt = (count_inc >= len_m2) ? sspf_pkg::PH_CHK : sspf_pkg::PH_DATA;
          end
          sspf_pkg::PH_CHK:  phase_nxt = chk_pass ? sspf_pkg::PH_DONE : sspf_pkg::PH_HUNT;
          sspf_pkg::PH_DONE: phase_nxt = sspf_pkg::PH_DONE;
          default: begin
            phase_nxt = (prev_sync_r && (in_rx_byte == sspf_pkg::HDR_BYTE)) ?
                        sspf_pkg::PH_ID : sspf_pkg::PH_HUNT;
          end
        endcase
      end
    end
  end

  always_comb begin
    prev_sync_nxt = prev_sync_r;
    ident_nxt     = ident_r;
    length_nxt    = length_r;
    status_nxt    = status_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    accept        = '0;
    wr_en         = 1'b0;
    wr_addr       = count_r[sspf_pkg::STORE_AW-1:0];
    wr_data       = in_rx_byte;
    if (in_fire) begin
      if (is_start) begin
        prev_sync_nxt = 1'b0;
        ident_nxt     = '0;
        length_nxt    = '0;
        status_nxt    = '0;
        count_nxt     = '0;
        sum_nxt       = '0;
      end else begin
        unique case (phase_r)
          sspf_pkg::PH_ID: begin
            ident_nxt = in_rx_byte;
            sum_nxt   = in_rx_byte;
          end
          sspf_pkg::PH_LEN: begin
            if (!len_bad) begin
              length_nxt = in_rx_byte[sspf_pkg::CNT_W-1:0];
              sum_nxt    = sum_add;
            end else if (ident_r == sspf_pkg::HDR_BYTE) begin
              // The old length byte becomes the id of a frame that starts one byte later.
              ident_nxt = in_rx_byte;
              sum_nxt   = in_rx_byte;
            end else begin
              prev_sync_nxt = (in_rx_byte == sspf_pkg::HDR_BYTE);
            end
          end
          sspf_pkg::PH_ERR: begin
            status_nxt = in_rx_byte;
            sum_nxt    = sum_add;
            count_nxt  = '0;
          end
          sspf_pkg::PH_DATA: begin
            wr_en     = 1'b1;
            sum_nxt   = sum_add;
            count_nxt = count_inc;
          end
          sspf_pkg::PH_CHK: begin
            if (chk_pass) begin
              accept.fire  = 1'b1;
              accept.count = wanted_count;
            end else begin
              prev_sync_nxt = 1'b0;
            end
          end
          sspf_pkg::PH_DONE: begin
            prev_sync_nxt = prev_sync_r;
          end
          default: begin
            prev_sync_nxt = !(prev_sync_r && (in_rx_byte == sspf_pkg::HDR_BYTE)) &&
                            (in_rx_byte == sspf_pkg::HDR_BYTE);
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= sspf_pkg::PH_HUNT;
      prev_sync_r <= 1'b0;
      ident_r     <= '0;
      length_r    <= '0;
      status_r    <= '0;
      count_r     <= '0;
      sum_r       <= '0;
    end else begin
      phase_r     <= phase_nxt;
      prev_sync_r <= prev_sync_nxt;
      ident_r     <= ident_nxt;
      length_r    <= length_nxt;
      status_r    <= status_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_write_not_ahead: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !(drain_stat.busy && (count_r >= drain_stat.rd_idx)))
    else $error("payload write would overtake the drain");

  a_accept_from_chk: assert property (@(posedge clk) disable iff (!rst_n)
    accept.fire |-> (phase_r == sspf_pkg::PH_CHK) && in_fire)
    else $error("frame accepted outside the checksum phase");

  a_accept_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    accept.fire |=> (phase_r == sspf_pkg::PH_DONE))
    else $error("accepted frame did not park the parser");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (count_r < sspf_pkg::CNT_W'(sspf_pkg::STORE_DEPTH)))
    else $error("payload write beyond the store");
`endif

endmodule

FILE: sv/sspf_drain.sv
`timescale 1ns / 1ps
// Reads the payload store for an accepted frame and delivers the bytes
// through an output register with a skid stage. Depends on sspf_pkg.

module sspf_drain (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sspf_pkg::accept_t             accept,
  output sspf_pkg::drain_stat_t         drain_stat,
  output logic                          rd_en,
  output logic [sspf_pkg::STORE_AW-1:0] rd_addr,
  input  logic [sspf_pkg::BYTE_W-1:0]   rd_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sspf_pkg::BYTE_W-1:0]   out_data_byte,
  output logic [sspf_pkg::CNT_W-1:0]    out_byte_index,
  output logic                          out_last
);

  logic [sspf_pkg::CNT_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [sspf_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        pend_r;
  logic [sspf_pkg::CNT_W-1:0]  pend_idx_r;
  logic                        pend_last_r;
  logic                        out_valid_r;
  logic [sspf_pkg::BYTE_W-1:0] out_data_r;
  logic [sspf_pkg::CNT_W-1:0]  out_idx_r;
  logic                        out_last_r;
  logic                        skid_valid_r;
  logic [sspf_pkg::BYTE_W-1:0] skid_data_r;
  logic [sspf_pkg::CNT_W-1:0]  skid_idx_r;
  logic                        skid_last_r;

  logic                        busy;
  logic                        take;
  logic                        out_free;
  logic [1:0]                  occ;
  logic [1:0]                  occ_after;
  logic                        issue;
  logic [sspf_pkg::CNT_W-1:0]  idx_inc;

  assign busy      = (rd_idx_r < cnt_r);
  assign take      = out_valid_r && !out_stall;
  assign out_free  = !out_valid_r || take;
  assign occ       = 2'(out_valid_r) + 2'(skid_valid_r) + 2'(pend_r);
  assign occ_after = occ - 2'(take);
  assign issue     = busy && (occ_after < 2'd2);
  assign idx_inc   = rd_idx_r + sspf_pkg::CNT_W'(1);

  assign rd_en   = issue;
  assign rd_addr = rd_idx_r[sspf_pkg::STORE_AW-1:0];

  assign drain_stat.busy   = busy;
  assign drain_stat.rd_idx = rd_idx_r;

  always_comb begin
    rd_idx_nxt = rd_idx_r;
    cnt_nxt    = cnt_r;
    if (accept.fire) begin
      rd_idx_nxt = '0;
      cnt_nxt    = accept.count;
    end else if (issue) begin
      rd_idx_nxt = idx_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r     <= '0;
      cnt_r        <= '0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      rd_idx_r <= rd_idx_nxt;
      cnt_r    <= cnt_nxt;
      pend_r   <= issue;
      if (out_free) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= pend_r;
        end else begin
          out_valid_r  <= pend_r;
        end
      end else if (pend_r) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    if (issue) begin
      pend_idx_r  <= rd_idx_r;
      pend_last_r <= (idx_inc == cnt_r);
    end
    if (out_free) begin
      if (skid_valid_r) begin
        out_data_r  <= skid_data_r;
        out_idx_r   <= skid_idx_r;
        out_last_r  <= skid_last_r;
        skid_data_r <= rd_data;
        skid_idx_r  <= pend_idx_r;
        skid_last_r <= pend_last_r;
      end else begin
        out_data_r  <= rd_data;
        out_idx_r   <= pend_idx_r;
        out_last_r  <= pend_last_r;
      end
    end else if (pend_r) begin
      skid_data_r <= rd_data;
      skid_idx_r  <= pend_idx_r;
      skid_last_r <= pend_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data_byte  = out_data_r;
  assign out_byte_index = out_idx_r;
  assign out_last       = out_last_r;

`ifndef NO_ASSERTIONS
  a_skid_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    !(pend_r && skid_valid_r && !out_free))
    else $error("read data arrived with output and skid both full");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds data while output register is empty");

  a_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> (rd_idx_r < sspf_pkg::CNT_W'(sspf_pkg::STORE_DEPTH)))
    else $error("store read beyond its depth");

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept.fire |-> !busy)
    else $error("new frame accepted while previous reads still pending");
`endif

endmodule

FILE: dv/servo_status_frame_parser_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for servo_status_frame_parser: drives byte and start
// transactions, predicts delivered payload bytes, and checks every output transaction.
// Depends on sspf_pkg and the servo_status_frame_parser RTL.

module servo_status_frame_parser_tb;

  localparam int IDLE_PCT    = 36;     // chance in a hundred that a side idles in a cycle
  localparam int DRAIN_WAIT  = 8;      // settling wait after the last owed output byte
  localparam int ITEM_TARGET = 300;    // input transactions before the random part stops
  localparam int TIMEOUT_NS  = 5_000_000;
  // Two header bytes, id, length, error, the largest payload and the checksum.
  localparam int FRAME_MAX   = sspf_pkg::MAX_LENGTH_FIELD + 4;

  // One delivered payload byte as seen on the output channel.
  typedef struct packed {
    logic [sspf_pkg::BYTE_W-1:0] data_byte;
    logic [sspf_pkg::CNT_W-1:0]  byte_index;
    logic                        last;
  } payload_beat_t;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic                        in_func;
  logic [sspf_pkg::BYTE_W-1:0] in_rx_byte;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [sspf_pkg::BYTE_W-1:0] out_data_byte;
  logic [sspf_pkg::CNT_W-1:0]  out_byte_index;
  logic                        out_last;
  logic                        cfg_we;
  logic [0:0]                  cfg_index;
  logic [sspf_pkg::BYTE_W-1:0] cfg_wdata;

  // When set, neither side idles; used for a long back-to-back stretch.
  bit quiet = 1'b0;
  int n_errors = 0;
  int n_items = 0;

  // Payload bytes the block still owes, oldest first.
  payload_beat_t pending_beats[$];

  // Shadow of the registers and of the parse state.
  logic [sspf_pkg::BYTE_W-1:0] exp_id;
  logic [sspf_pkg::CNT_W-1:0]  want_cnt;
  sspf_pkg::phase_t            ph;
  logic                        sync_seen;
  logic [sspf_pkg::BYTE_W-1:0] cur_id;
  logic [sspf_pkg::CNT_W-1:0]  cur_len;
  logic [sspf_pkg::BYTE_W-1:0] cur_err;
  int                          nbytes;
  logic [sspf_pkg::BYTE_W-1:0] csum;
  logic [sspf_pkg::BYTE_W-1:0] pay [sspf_pkg::STORE_DEPTH];

  servo_status_frame_parser dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data_byte  (out_data_byte),
    .out_byte_index (out_byte_index),
    .out_last       (out_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #5 clk = ~clk;

  // The receiver stalls at random unless a quiet stretch is running.
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // A start transaction throws away any partial frame and the delivered state.
  task automatic clear_parse_state();
    ph        = sspf_pkg::PH_HUNT;
    sync_seen = 1'b0;
    cur_id    = '0;
    cur_len   = '0;
    cur_err   = '0;
    nbytes    = 0;
    csum      = '0;
  endtask

  // Advances the shadow parser by one accepted input transaction and queues the
  // payload bytes that an accepted frame delivers.
  task automatic track_item(input logic f, input logic [sspf_pkg::BYTE_W-1:0] b);
    payload_beat_t beat;
    if (f == sspf_pkg::FUNC_START) begin
      clear_parse_state();
      return;
    end
    case (ph)
      sspf_pkg::PH_ID: begin
        cur_id = b;
        csum   = b;
        ph     = sspf_pkg::PH_LEN;
      end
      sspf_pkg::PH_LEN: begin
        if (b < sspf_pkg::MIN_LENGTH_FIELD || b > sspf_pkg::MAX_LENGTH_FIELD) begin
          // Bad length: the shadow hunts again, with only this byte as a header
          // candidate. An id of 0xFF instead makes this byte the new id.
          if (cur_id == sspf_pkg::HDR_BYTE) begin
            cur_id = b;
            csum   = b;
          end else begin
            ph        = sspf_pkg::PH_HUNT;
            sync_seen = (b == sspf_pkg::HDR_BYTE);
          end
        end else begin
          cur_len = b[sspf_pkg::CNT_W-1:0];
          csum    = csum + b;
          ph      = sspf_pkg::PH_ERR;
        end
      end
      sspf_pkg::PH_ERR: begin
        cur_err = b;
        csum    = csum + b;
        nbytes  = 0;
        ph      = (cur_len > sspf_pkg::MIN_LENGTH_FIELD) ? sspf_pkg::PH_DATA
                                                         : sspf_pkg::PH_CHK;
      end
      sspf_pkg::PH_DATA: begin
        if (nbytes < sspf_pkg::STORE_DEPTH) pay[nbytes] = b;
        csum = csum + b;
        nbytes++;
        if (nbytes >= int'(cur_len) - sspf_pkg::MIN_LENGTH_FIELD) ph = sspf_pkg::PH_CHK;
      end
      sspf_pkg::PH_CHK: begin
        if (cur_id == exp_id && cur_err == '0 && b == sspf_pkg::BYTE_W'(~csum) &&
            int'(cur_len) - sspf_pkg::MIN_LENGTH_FIELD >= int'(want_cnt) &&
            int'(want_cnt) <= sspf_pkg::STORE_DEPTH) begin
          for (int i = 0; i < int'(want_cnt); i++) begin
            beat.data_byte  = pay[i];
            beat.byte_index = i[sspf_pkg::CNT_W-1:0];
            beat.last       = (i + 1 == int'(want_cnt));
            pending_beats.insert(pending_beats.size(), beat);
          end
          ph = sspf_pkg::PH_DONE;
        end else begin
          ph        = sspf_pkg::PH_HUNT;
          sync_seen = 1'b0;
        end
      end
      sspf_pkg::PH_DONE: begin
        // Everything is ignored until the next start.
      end
      default: begin
        if (sync_seen && b == sspf_pkg::HDR_BYTE) begin
          ph        = sspf_pkg::PH_ID;
          sync_seen = 1'b0;
        end else begin
          ph        = sspf_pkg::PH_HUNT;
          sync_seen = (b == sspf_pkg::HDR_BYTE);
        end
      end
    endcase
  endtask

  // Offers one input transaction, with random idle cycles ahead of it, and
  // returns at the clock edge where the block takes it.
  task automatic send_item(input logic f, input logic [sspf_pkg::BYTE_W-1:0] b);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_func    <= f;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    track_item(f, b);
    n_items++;
  endtask

  // Stops input, waits for every owed byte, then lets the block go quiet.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [sspf_pkg::BYTE_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == sspf_pkg::CFG_EXPECTED_ID) exp_id = val;
    else want_cnt = val[sspf_pkg::CNT_W-1:0];
    @(posedge clk);
  endtask

  task automatic set_registers(input logic [sspf_pkg::BYTE_W-1:0] id,
                               input logic [sspf_pkg::BYTE_W-1:0] cnt);
    settle();
    write_reg(sspf_pkg::CFG_EXPECTED_ID, id);
    write_reg(sspf_pkg::CFG_WANTED_COUNT, cnt);
  endtask

  // Sends a frame with random payload. An out-of-range length is followed by a
  // few random bytes instead of a payload. A cut >= 0 shorter than the frame truncates it.
  task automatic send_frame(input logic [sspf_pkg::BYTE_W-1:0] id,
                            input logic [sspf_pkg::BYTE_W-1:0] len,
                            input logic [sspf_pkg::BYTE_W-1:0] err,
                            input bit bad_chk, input int cut);
    logic [sspf_pkg::BYTE_W-1:0] frame_bytes [FRAME_MAX];
    logic [sspf_pkg::BYTE_W-1:0] sum;
    int                          n_pay;
    int                          n_bytes;
    frame_bytes[0] = sspf_pkg::HDR_BYTE;
    frame_bytes[1] = sspf_pkg::HDR_BYTE;
    frame_bytes[2] = id;
    frame_bytes[3] = len;
    frame_bytes[4] = err;
    sum = id + len + err;
    if (len >= sspf_pkg::MIN_LENGTH_FIELD && len <= sspf_pkg::MAX_LENGTH_FIELD)
      n_pay = len - sspf_pkg::MIN_LENGTH_FIELD;
    else n_pay = $urandom_range(0, 3);
    for (int i = 0; i < n_pay; i++) begin
      frame_bytes[5 + i] = sspf_pkg::BYTE_W'($urandom);
      sum = sum + frame_bytes[5 + i];
    end
    n_bytes = 5 + n_pay;
    frame_bytes[n_bytes] = bad_chk ?
        sspf_pkg::BYTE_W'(~sum) ^ sspf_pkg::BYTE_W'($urandom_range(1, 255)) :
        sspf_pkg::BYTE_W'(~sum);
    n_bytes++;
    if (cut < 0 || cut > n_bytes) cut = n_bytes;
    for (int i = 0; i < cut; i++) send_item(sspf_pkg::FUNC_BYTE, frame_bytes[i]);
  endtask

  // Mostly lengths just large enough for the wanted count, so most frames pass.
  function automatic logic [sspf_pkg::BYTE_W-1:0] pick_len();
    int lo;
    int room;
    if (want_cnt >= 1 && int'(want_cnt) <= sspf_pkg::STORE_DEPTH &&
        $urandom_range(0, 99) < 85) begin
      lo   = int'(want_cnt) + sspf_pkg::MIN_LENGTH_FIELD;
      room = sspf_pkg::MAX_LENGTH_FIELD - lo;
      return sspf_pkg::BYTE_W'(lo + $urandom_range(0, (room < 2) ? room : 2));
    end
    if ($urandom_range(0, 9) == 0) return sspf_pkg::BYTE_W'(sspf_pkg::MAX_LENGTH_FIELD);
    return sspf_pkg::BYTE_W'($urandom_range(sspf_pkg::MIN_LENGTH_FIELD, 6));
  endfunction

  // One request cycle: usually a start, sometimes line noise, then a frame that
  // is well formed most of the time and otherwise broken in one way.
  task automatic send_random_frame();
    logic [sspf_pkg::BYTE_W-1:0] id;
    logic [sspf_pkg::BYTE_W-1:0] len;
    logic [sspf_pkg::BYTE_W-1:0] err;
    bit                          bad_chk;
    int                          cut;
    int                          k;
    if ($urandom_range(0, 99) < 90)
      send_item(sspf_pkg::FUNC_START, sspf_pkg::BYTE_W'($urandom));
    if ($urandom_range(0, 99) < 20) begin
      repeat ($urandom_range(1, 3))
        send_item(sspf_pkg::FUNC_BYTE, $urandom_range(0, 1) ? sspf_pkg::HDR_BYTE
                                                            : sspf_pkg::BYTE_W'($urandom));
    end
    id      = exp_id;
    len     = pick_len();
    err     = '0;
    bad_chk = 1'b0;
    cut     = -1;
    k       = $urandom_range(0, 99);
    if (k < 8) id = sspf_pkg::BYTE_W'($urandom);
    else if (k < 14) err = sspf_pkg::BYTE_W'($urandom_range(1, 255));
    else if (k < 20) bad_chk = 1'b1;
    else if (k < 26) len = $urandom_range(0, 1) ? sspf_pkg::BYTE_W'($urandom_range(0, 1))
                                               : sspf_pkg::BYTE_W'($urandom_range(21, 255));
    else if (k < 30) cut = $urandom_range(1, int'(len) + 3);
    send_frame(id, len, err, bad_chk, cut);
  endtask

  // Reset values of the registers: id 1 and two bytes wanted. The frame also
  // carries a 0xFF id followed by an out-of-range length, which must make the
  // length byte the new id. A byte after the delivered frame must be ignored.
  task automatic test_reset_registers();
    send_item(sspf_pkg::FUNC_START, 8'h00);
    send_item(sspf_pkg::FUNC_BYTE, 8'hFF);
    send_item(sspf_pkg::FUNC_BYTE, 8'hFF);
    send_item(sspf_pkg::FUNC_BYTE, 8'hFF);
    send_item(sspf_pkg::FUNC_BYTE, 8'h01);
    send_item(sspf_pkg::FUNC_BYTE, 8'h04);
    send_item(sspf_pkg::FUNC_BYTE, 8'h00);
    send_item(sspf_pkg::FUNC_BYTE, 8'h00);
    send_item(sspf_pkg::FUNC_BYTE, 8'hFF);
    send_item(sspf_pkg::FUNC_BYTE, 8'hFB);
    send_item(sspf_pkg::FUNC_BYTE, 8'h55);
  endtask

  // Dropped frames: a length above the limit, a frame with no payload while
  // two bytes are wanted, and a frame with a nonzero error byte.
  task automatic test_dropped_frames();
    send_item(sspf_pkg::FUNC_START, 8'hFF);
    send_item(sspf_pkg::FUNC_BYTE, 8'hFF);
    send_item(sspf_pkg::FUNC_BYTE, 8'hFF);
    send_item(sspf_pkg::FUNC_BYTE, 8'h01);
    send_item(sspf_pkg::FUNC_BYTE, 8'h15);
    send_item(sspf_pkg::FUNC_BYTE, 8'hFF);
    send_item(sspf_pkg::FUNC_BYTE, 8'hFF);
    send_item(sspf_pkg::FUNC_BYTE, 8'h01);
    send_item(sspf_pkg::FUNC_BYTE, 8'h02);
    send_item(sspf_pkg::FUNC_BYTE, 8'h00);
    send_item(sspf_pkg::FUNC_BYTE, 8'hFC);
    send_item(sspf_pkg::FUNC_BYTE, 8'hFF);
    send_item(sspf_pkg::FUNC_BYTE, 8'hFF);
    send_item(sspf_pkg::FUNC_BYTE, 8'h01);
    send_item(sspf_pkg::FUNC_BYTE, 8'h03);
    send_item(sspf_pkg::FUNC_BYTE, 8'h07);
    send_item(sspf_pkg::FUNC_BYTE, 8'hAA);
    send_item(sspf_pkg::FUNC_BYTE, 8'h4A);
  endtask

  // Register extremes, a zero wanted count, and wanted counts that no frame
  // can satisfy, each with a few random frames.
  task automatic test_register_sweep();
    logic [sspf_pkg::BYTE_W-1:0] ids  [6] = '{8'h00, 8'hFF, 8'h5A, 8'h33, 8'h81, 8'h01};
    logic [sspf_pkg::BYTE_W-1:0] cnts [6] = '{8'd1, 8'd18, 8'd0, 8'd31, 8'd19, 8'd2};
    for (int s = 0; s < 6; s++) begin
      set_registers(ids[s], cnts[s]);
      repeat (2) send_random_frame();
    end
  endtask

  // Random settings with small wanted counts; the first rounds form one long
  // stretch in which neither side idles at all.
  task automatic test_random_traffic();
    int round;
    round = 0;
    while (n_items < ITEM_TARGET) begin
      set_registers(sspf_pkg::BYTE_W'($urandom),
                    $urandom_range(0, 9) == 0 ? sspf_pkg::BYTE_W'($urandom_range(1, 18))
                                              : sspf_pkg::BYTE_W'($urandom_range(1, 6)));
      quiet = (round < 2);
      repeat (4) send_random_frame();
      round++;
    end
    quiet = 1'b0;
  endtask

  // Compares each output transaction with the oldest owed byte.
  always @(posedge clk) begin : result_monitor
    payload_beat_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_beats.size() == 0) begin
        $error("unexpected output: data_byte %0h byte_index %0d last %0b",
               out_data_byte, out_byte_index, out_last);
        n_errors++;
      end else begin
        want = pending_beats.pop_front();
        if (out_data_byte !== want.data_byte) begin
          $error("data_byte mismatch: expected %0h, actual %0h",
                 want.data_byte, out_data_byte);
          n_errors++;
        end
        if (out_byte_index !== want.byte_index) begin
          $error("byte_index mismatch: expected %0d, actual %0d",
                 want.byte_index, out_byte_index);
          n_errors++;
        end
        if (out_last !== want.last) begin
          $error("last mismatch: expected %0b, actual %0b", want.last, out_last);
          n_errors++;
        end
      end
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_func    = sspf_pkg::FUNC_BYTE;
    in_rx_byte = '0;
    cfg_we     = 1'b0;
    cfg_index  = sspf_pkg::CFG_EXPECTED_ID;
    cfg_wdata  = '0;
    exp_id     = 8'd1;
    want_cnt   = 5'd2;
    clear_parse_state();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_registers();
    test_dropped_frames();
    test_register_sweep();
    test_random_traffic();
    settle();

    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Test completed with failures");
    $finish;
  end

endmodule
